FILE: rtl/nar_pkg.sv
package nar_pkg;

  localparam int MEM_BYTES  = 1024;
  localparam int USER_START = 16;
  localparam int USER_END   = 520;
  localparam int PKG_BYTES  = 256;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int PKG_AW = $clog2(PKG_BYTES);
  localparam int OFF_W  = 18;
  localparam int CUR_W  = 34;
  localparam int TOT_W  = 13;
  localparam int NLEN_W = 17;

  localparam logic [7:0] TLV_NDEF = 8'h03;
  localparam logic [7:0] TLV_NULL = 8'h00;
  localparam logic [7:0] TLV_TERM = 8'hFE;
  localparam logic [7:0] LEN_LONG = 8'hFF;
  localparam int FLAG_CF_BIT = 5;
  localparam int FLAG_ME_BIT = 6;
  localparam int FLAG_SR_BIT = 4;
  localparam int FLAG_IL_BIT = 3;
  localparam logic [7:0] AAR_HDR       = 8'h54;
  localparam logic [7:0] TYPE_NAME_LEN = 8'd15;
  localparam logic [7:0] AAR_FIXED_LEN = 8'd18;

  localparam logic [1:0] OP_LOAD_TAG = 2'd0;
  localparam logic [1:0] OP_LOAD_PKG = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_INJECT   = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_ARGS  = 4'd1;
  localparam logic [3:0] ST_TERM      = 4'd2;
  localparam logic [3:0] ST_NO_NDEF   = 4'd3;
  localparam logic [3:0] ST_BAD_LEN   = 4'd4;
  localparam logic [3:0] ST_EMPTY     = 4'd5;
  localparam logic [3:0] ST_CHUNKED   = 4'd6;
  localparam logic [3:0] ST_NO_REC    = 4'd7;
  localparam logic [3:0] ST_SHORT_OVF = 4'd8;
  localparam logic [3:0] ST_NO_ROOM   = 4'd9;

  localparam logic [1:0] SRC_OFF  = 2'd0;
  localparam logic [1:0] SRC_CUR  = 2'd1;
  localparam logic [1:0] SRC_LAST = 2'd2;
  localparam logic [1:0] SRC_IN   = 2'd3;

  localparam logic [4:0] ACT_NONE      = 5'd0;
  localparam logic [4:0] ACT_LOADT     = 5'd1;
  localparam logic [4:0] ACT_LOADP     = 5'd2;
  localparam logic [4:0] ACT_RDRES     = 5'd3;
  localparam logic [4:0] ACT_INIT      = 5'd4;
  localparam logic [4:0] ACT_OFF_INC1  = 5'd5;
  localparam logic [4:0] ACT_OFF_SHORT = 5'd6;
  localparam logic [4:0] ACT_HI        = 5'd7;
  localparam logic [4:0] ACT_OFF_LONG  = 5'd8;
  localparam logic [4:0] ACT_MSG_SHORT = 5'd9;
  localparam logic [4:0] ACT_MSG_LONG  = 5'd10;
  localparam logic [4:0] ACT_WALK_INIT = 5'd11;
  localparam logic [4:0] ACT_H         = 5'd12;
  localparam logic [4:0] ACT_TL        = 5'd13;
  localparam logic [4:0] ACT_PL_LOAD   = 5'd14;
  localparam logic [4:0] ACT_PL_SHIFT  = 5'd15;
  localparam logic [4:0] ACT_IDL       = 5'd16;
  localparam logic [4:0] ACT_IDL0      = 5'd17;
  localparam logic [4:0] ACT_NEXT      = 5'd18;
  localparam logic [4:0] ACT_WP_END    = 5'd19;
  localparam logic [4:0] ACT_WR_ME     = 5'd20;
  localparam logic [4:0] ACT_WR_HDR    = 5'd21;
  localparam logic [4:0] ACT_WR_TL     = 5'd22;
  localparam logic [4:0] ACT_WR_PL     = 5'd23;
  localparam logic [4:0] ACT_WR_TYPE   = 5'd24;
  localparam logic [4:0] ACT_WR_PKG    = 5'd25;
  localparam logic [4:0] ACT_WR_TERM   = 5'd26;
  localparam logic [4:0] ACT_WR_LEN1   = 5'd27;
  localparam logic [4:0] ACT_WR_LENH   = 5'd28;
  localparam logic [4:0] ACT_WR_LENL   = 5'd29;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] address;
    logic [7:0] data;
    logic [7:0] package_length;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  read_data;
    logic [3:0]  status;
    logic [15:0] new_message_length;
  } result_t;

  typedef struct packed {
    logic [4:0] act;
    logic [1:0] rd_src;
    logic [2:0] rd_k;
    logic       fin;
    logic [3:0] status;
  } cmd_t;

  typedef struct packed {
    logic args_bad;
    logic off_end;
    logic b_ndef;
    logic b_null;
    logic b_term;
    logic b_ff;
    logic b_cf;
    logic len_bad;
    logic msg_empty;
    logic cur_done;
    logic c1_end;
    logic c2_end;
    logic c5_end;
    logic h_sr;
    logic h_il;
    logic h_me;
    logic seen;
    logic short_ovf;
    logic no_room;
    logic hdr_long;
    logic idx_type_last;
    logic idx_pkg_last;
  } stat_t;

  function automatic logic [7:0] aar_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = "a";
      4'd1:    c = "n";
      4'd2:    c = "d";
      4'd3:    c = "r";
      4'd4:    c = "o";
      4'd5:    c = "i";
      4'd6:    c = "d";
      4'd7:    c = ".";
      4'd8:    c = "c";
      4'd9:    c = "o";
      4'd10:   c = "m";
      4'd11:   c = ":";
      4'd12:   c = "p";
      4'd13:   c = "k";
      4'd14:   c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/ndef_aar_record_append.sv
// NDEF record append block for a Type 2 tag image.
// Input: item (operation, address, data, package_length) taken when start is
// high and busy is low. Loads of a tag byte or a package-name byte give no
// result; the next item may follow at once.
// A tag read gives one result; busy is high for its read state S_RD.
// An inject reads tag RAM through one registered port: the argument check,
// a walk over NULL TLVs and other short- or long-form TLVs, taking a short
// or long NDEF TLV header, a walk over the record headers (short or long
// payload length, with or without ID length), the final checks, then the
// append, with a short or long TLV length. busy stays high meanwhile; the
// result is valid in the same cycle in which busy drops.
// Results come on result with result_valid high for one cycle; the receiver
// must take them, there is no backpressure.
// cfg_we/cfg_data write tag_size (reset 540); write only while idle.
// Reset clears the controller and result_valid and sets tag_size to 540;
// tag and package RAMs are not cleared and must be loaded before use.
module ndef_aar_record_append import nar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  output result_t     result,
  output logic        result_valid
);

  cmd_t  cmd;
  stat_t stat;

  nar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  nar_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without work");
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.kind) |->
      (result.status == ST_OK && result.new_message_length == 16'd0))
    else $error("read result carries status");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> result.new_message_length == 16'd0)
    else $error("failed inject reports length");

endmodule

FILE: rtl/nar_ram.sv
module nar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nar_dp.sv
module nar_dp import nar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output result_t     result,
  output logic        result_valid
);

  logic [10:0]       tag_size;
  logic [TOT_W-1:0]  total;
  logic [7:0]        plen;
  logic [OFF_W-1:0]  off;
  logic [7:0]        hi;
  logic [15:0]       msg_len;
  logic [OFF_W-1:0]  msg_off;
  logic              hdr_long;
  logic [OFF_W-1:0]  end_pos;
  logic [CUR_W-1:0]  cur;
  logic [7:0]        h;
  logic [7:0]        tl;
  logic [31:0]       pl;
  logic [7:0]        idl;
  logic [OFF_W-1:0]  last;
  logic              seen;
  logic [OFF_W-1:0]  wp;
  logic [7:0]        idx;
  logic              oob_q;
  result_t           res_q;
  logic              valid_q;

  logic [7:0]        tag_rdata;
  logic [7:0]        pkg_rdata;
  logic [7:0]        rbyte;
  logic [CUR_W-1:0]  rd_base;
  logic [CUR_W-1:0]  rd_full;
  logic [OFF_W-1:0]  wa_full;
  logic [7:0]        wd;
  logic              wr_act;
  logic              tag_we;
  logic              pkg_we;
  logic [NLEN_W-1:0] nlen;
  logic [TOT_W-1:0]  tot_calc;
  logic [OFF_W:0]    msg_end;
  logic [OFF_W:0]    room_end;
  logic [OFF_W:0]    off_p2;
  logic [3:0]        ht;

  assign rbyte = oob_q ? 8'h00 : tag_rdata;
  assign nlen  = NLEN_W'(msg_len) + NLEN_W'(AAR_FIXED_LEN) + NLEN_W'(plen);
  assign msg_end  = (OFF_W+1)'(msg_off) + (OFF_W+1)'(msg_len);
  assign room_end = (OFF_W+1)'(msg_off) + (OFF_W+1)'(nlen) + (OFF_W+1)'(1);
  assign off_p2   = (OFF_W+1)'(off) + (OFF_W+1)'(2);
  assign ht = h[FLAG_SR_BIT] ? (4'd3 + {3'd0, h[FLAG_IL_BIT]})
                             : (4'd6 + {3'd0, h[FLAG_IL_BIT]});

  always_comb begin
    tot_calc = TOT_W'(tag_size);
    if (tot_calc > TOT_W'(USER_END)) begin
      tot_calc = TOT_W'(USER_END);
    end
    if (tot_calc > TOT_W'(MEM_BYTES)) begin
      tot_calc = TOT_W'(MEM_BYTES);
    end
  end

  always_comb begin
    case (cmd.rd_src)
      SRC_OFF:  rd_base = CUR_W'(off);
      SRC_CUR:  rd_base = cur;
      SRC_LAST: rd_base = CUR_W'(last);
      default:  rd_base = CUR_W'(item.address);
    endcase
    rd_full = rd_base + CUR_W'(cmd.rd_k);
  end

  always_comb begin
    wr_act = 1'b1;
    wa_full = wp;
    wd = 8'h00;
    case (cmd.act)
      ACT_LOADT: begin
        wa_full = OFF_W'(item.address);
        wd = item.data;
      end
      ACT_WR_ME: begin
        wa_full = last;
        wd = rbyte & ~(8'h01 << FLAG_ME_BIT);
      end
      ACT_WR_HDR:  wd = AAR_HDR;
      ACT_WR_TL:   wd = TYPE_NAME_LEN;
      ACT_WR_PL:   wd = plen;
      ACT_WR_TYPE: wd = aar_char(idx[3:0]);
      ACT_WR_PKG:  wd = pkg_rdata;
      ACT_WR_TERM: wd = TLV_TERM;
      ACT_WR_LEN1: begin
        wa_full = off + OFF_W'(1);
        wd = nlen[7:0];
      end
      ACT_WR_LENH: begin
        wa_full = off + OFF_W'(2);
        wd = nlen[15:8];
      end
      ACT_WR_LENL: begin
        wa_full = off + OFF_W'(3);
        wd = nlen[7:0];
      end
      default: wr_act = 1'b0;
    endcase
  end

  assign tag_we = wr_act && (wa_full < OFF_W'(MEM_BYTES));
  assign pkg_we = (cmd.act == ACT_LOADP) && ({1'b0, item.address} < 11'(PKG_BYTES));

  nar_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wa_full[MEM_AW-1:0]),
    .wdata (wd),
    .raddr (rd_full[MEM_AW-1:0]),
    .rdata (tag_rdata)
  );

  nar_ram #(.WIDTH(8), .DEPTH(PKG_BYTES)) u_pkg_ram (
    .clk   (clk),
    .we    (pkg_we),
    .waddr (item.address[PKG_AW-1:0]),
    .wdata (item.data),
    .raddr (idx[PKG_AW-1:0]),
    .rdata (pkg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_size <= 11'd540;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tag_size <= cfg_data;
      end
      valid_q <= (cmd.act == ACT_RDRES) || cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    oob_q <= rd_full >= CUR_W'(MEM_BYTES);
    if (cmd.act == ACT_RDRES) begin
      res_q <= '{kind: 1'b0, read_data: rbyte, status: ST_OK, new_message_length: 16'd0};
    end else if (cmd.fin) begin
      res_q <= '{kind: 1'b1, read_data: 8'h00, status: cmd.status,
                 new_message_length: (cmd.status == ST_OK) ? nlen[15:0] : 16'd0};
    end
    case (cmd.act)
      ACT_INIT: begin
        plen  <= item.package_length;
        total <= tot_calc;
        off   <= OFF_W'(USER_START);
      end
      ACT_OFF_INC1:  off <= off + OFF_W'(1);
      ACT_OFF_SHORT: off <= off + OFF_W'(2) + OFF_W'(rbyte);
      ACT_HI:        hi <= rbyte;
      ACT_OFF_LONG:  off <= off + OFF_W'(4) + OFF_W'({hi, rbyte});
      ACT_MSG_SHORT: begin
        hdr_long <= 1'b0;
        msg_len  <= {8'd0, rbyte};
        msg_off  <= off + OFF_W'(2);
      end
      ACT_MSG_LONG: begin
        hdr_long <= 1'b1;
        msg_len  <= {hi, rbyte};
        msg_off  <= off + OFF_W'(4);
      end
      ACT_WALK_INIT: begin
        cur     <= CUR_W'(msg_off);
        end_pos <= msg_end[OFF_W-1:0];
        seen    <= 1'b0;
      end
      ACT_H:        h <= rbyte;
      ACT_TL:       tl <= rbyte;
      ACT_PL_LOAD:  pl <= {24'd0, rbyte};
      ACT_PL_SHIFT: pl <= {pl[23:0], rbyte};
      ACT_IDL:      idl <= rbyte;
      ACT_IDL0:     idl <= 8'd0;
      ACT_NEXT: begin
        last <= cur[OFF_W-1:0];
        seen <= 1'b1;
        cur  <= cur + CUR_W'(ht) + CUR_W'(tl) + CUR_W'(idl) + CUR_W'(pl);
      end
      ACT_WP_END: begin
        wp  <= end_pos;
        idx <= 8'd0;
      end
      ACT_WR_HDR, ACT_WR_TL, ACT_WR_PL: wp <= wp + OFF_W'(1);
      ACT_WR_TYPE: begin
        wp  <= wp + OFF_W'(1);
        idx <= (idx == 8'd14) ? 8'd0 : idx + 8'd1;
      end
      ACT_WR_PKG: begin
        wp  <= wp + OFF_W'(1);
        idx <= idx + 8'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.args_bad  = (plen == 8'd0) || (tag_size <= 11'(USER_START));
    stat.off_end   = off_p2 >= (OFF_W+1)'(total);
    stat.b_ndef    = rbyte == TLV_NDEF;
    stat.b_null    = rbyte == TLV_NULL;
    stat.b_term    = rbyte == TLV_TERM;
    stat.b_ff      = rbyte == LEN_LONG;
    stat.b_cf      = rbyte[FLAG_CF_BIT];
    stat.len_bad   = msg_end > (OFF_W+1)'(total);
    stat.msg_empty = msg_len == 16'd0;
    stat.cur_done  = cur >= CUR_W'(end_pos);
    stat.c1_end    = (cur + CUR_W'(1)) >= CUR_W'(end_pos);
    stat.c2_end    = (cur + CUR_W'(2)) >= CUR_W'(end_pos);
    stat.c5_end    = (cur + CUR_W'(5)) >= CUR_W'(end_pos);
    stat.h_sr      = h[FLAG_SR_BIT];
    stat.h_il      = h[FLAG_IL_BIT];
    stat.h_me      = h[FLAG_ME_BIT];
    stat.seen      = seen;
    stat.short_ovf = !hdr_long && (nlen >= NLEN_W'(255));
    stat.no_room   = room_end > (OFF_W+1)'(total);
    stat.hdr_long  = hdr_long;
    stat.idx_type_last = idx == 8'd14;
    stat.idx_pkg_last  = idx == (plen - 8'd1);
  end

  assign result       = res_q;
  assign result_valid = valid_q;

endmodule

FILE: rtl/nar_ctrl.sv
module nar_ctrl import nar_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_RD    = 6'd1;
  localparam logic [5:0] S_ARGS  = 6'd2;
  localparam logic [5:0] S_TCHK  = 6'd3;
  localparam logic [5:0] S_TB0   = 6'd4;
  localparam logic [5:0] S_TB1   = 6'd5;
  localparam logic [5:0] S_TB2   = 6'd6;
  localparam logic [5:0] S_TB3   = 6'd7;
  localparam logic [5:0] S_NB1   = 6'd8;
  localparam logic [5:0] S_NB2   = 6'd9;
  localparam logic [5:0] S_NB3   = 6'd10;
  localparam logic [5:0] S_NCHK  = 6'd11;
  localparam logic [5:0] S_WCHK  = 6'd12;
  localparam logic [5:0] S_WH    = 6'd13;
  localparam logic [5:0] S_WTL   = 6'd14;
  localparam logic [5:0] S_WPS   = 6'd15;
  localparam logic [5:0] S_WP2   = 6'd16;
  localparam logic [5:0] S_WP3   = 6'd17;
  localparam logic [5:0] S_WP4   = 6'd18;
  localparam logic [5:0] S_WP5   = 6'd19;
  localparam logic [5:0] S_WID   = 6'd20;
  localparam logic [5:0] S_WIDD  = 6'd21;
  localparam logic [5:0] S_WNEXT = 6'd22;
  localparam logic [5:0] S_WDONE = 6'd23;
  localparam logic [5:0] S_AMEW  = 6'd24;
  localparam logic [5:0] S_AHDR  = 6'd25;
  localparam logic [5:0] S_ATL   = 6'd26;
  localparam logic [5:0] S_APL   = 6'd27;
  localparam logic [5:0] S_ATYPE = 6'd28;
  localparam logic [5:0] S_APKR  = 6'd29;
  localparam logic [5:0] S_APKW  = 6'd30;
  localparam logic [5:0] S_ATERM = 6'd31;
  localparam logic [5:0] S_ALEN  = 6'd32;
  localparam logic [5:0] S_ALEN2 = 6'd33;

  logic [5:0] state;
  logic [5:0] state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{act: ACT_NONE, rd_src: SRC_OFF, rd_k: 3'd0, fin: 1'b0, status: ST_OK};
    case (state)
      S_IDLE: begin
        cmd.rd_src = SRC_IN;
        if (start) begin
          case (operation)
            OP_LOAD_TAG: cmd.act = ACT_LOADT;
            OP_LOAD_PKG: cmd.act = ACT_LOADP;
            OP_READ:     state_next = S_RD;
            default: begin
              cmd.act = ACT_INIT;
              state_next = S_ARGS;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.act = ACT_RDRES;
        state_next = S_IDLE;
      end
      S_ARGS: begin
        if (stat.args_bad) begin
          cmd.fin = 1'b1;
          cmd.status = ST_BAD_ARGS;
          state_next = S_IDLE;
        end else begin
          state_next = S_TCHK;
        end
      end
      S_TCHK: begin
        if (stat.off_end) begin
          cmd.fin = 1'b1;
          cmd.status = ST_NO_NDEF;
          state_next = S_IDLE;
        end else begin
          state_next = S_TB0;
        end
      end
      S_TB0: begin
        cmd.rd_k = 3'd1;
        if (stat.b_ndef) begin
          state_next = S_NB1;
        end else if (stat.b_null) begin
          cmd.act = ACT_OFF_INC1;
          state_next = S_TCHK;
        end else if (stat.b_term) begin
          cmd.fin = 1'b1;
          cmd.status = ST_TERM;
          state_next = S_IDLE;
        end else begin
          state_next = S_TB1;
        end
      end
      S_TB1: begin
        cmd.rd_k = 3'd2;
        if (stat.b_ff) begin
          state_next = S_TB2;
        end else begin
          cmd.act = ACT_OFF_SHORT;
          state_next = S_TCHK;
        end
      end
      S_TB2: begin
        cmd.act = ACT_HI;
        cmd.rd_k = 3'd3;
        state_next = S_TB3;
      end
      S_TB3: begin
        cmd.act = ACT_OFF_LONG;
        state_next = S_TCHK;
      end
      S_NB1: begin
        cmd.rd_k = 3'd2;
        if (stat.b_ff) begin
          state_next = S_NB2;
        end else begin
          cmd.act = ACT_MSG_SHORT;
          state_next = S_NCHK;
        end
      end
      S_NB2: begin
        cmd.act = ACT_HI;
        cmd.rd_k = 3'd3;
        state_next = S_NB3;
      end
      S_NB3: begin
        cmd.act = ACT_MSG_LONG;
        state_next = S_NCHK;
      end
      S_NCHK: begin
        if (stat.len_bad) begin
          cmd.fin = 1'b1;
          cmd.status = ST_BAD_LEN;
          state_next = S_IDLE;
        end else if (stat.msg_empty) begin
          cmd.fin = 1'b1;
          cmd.status = ST_EMPTY;
          state_next = S_IDLE;
        end else begin
          cmd.act = ACT_WALK_INIT;
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        cmd.rd_src = SRC_CUR;
        state_next = stat.cur_done ? S_WDONE : S_WH;
      end
      S_WH: begin
        cmd.act = ACT_H;
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = 3'd1;
        if (stat.b_cf) begin
          cmd.fin = 1'b1;
          cmd.status = ST_CHUNKED;
          state_next = S_IDLE;
        end else begin
          state_next = stat.c1_end ? S_WDONE : S_WTL;
        end
      end
      S_WTL: begin
        cmd.act = ACT_TL;
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = 3'd2;
        if (stat.h_sr) begin
          state_next = stat.c2_end ? S_WDONE : S_WPS;
        end else begin
          state_next = stat.c5_end ? S_WDONE : S_WP2;
        end
      end
      S_WPS: begin
        cmd.act = ACT_PL_LOAD;
        state_next = S_WID;
      end
      S_WP2: begin
        cmd.act = ACT_PL_SHIFT;
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = 3'd3;
        state_next = S_WP3;
      end
      S_WP3: begin
        cmd.act = ACT_PL_SHIFT;
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = 3'd4;
        state_next = S_WP4;
      end
      S_WP4: begin
        cmd.act = ACT_PL_SHIFT;
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = 3'd5;
        state_next = S_WP5;
      end
      S_WP5: begin
        cmd.act = ACT_PL_SHIFT;
        state_next = S_WID;
      end
      S_WID: begin
        cmd.rd_src = SRC_CUR;
        cmd.rd_k = stat.h_sr ? 3'd3 : 3'd6;
        if (stat.h_il) begin
          state_next = S_WIDD;
        end else begin
          cmd.act = ACT_IDL0;
          state_next = S_WNEXT;
        end
      end
      S_WIDD: begin
        cmd.act = ACT_IDL;
        state_next = S_WNEXT;
      end
      S_WNEXT: begin
        cmd.act = ACT_NEXT;
        state_next = stat.h_me ? S_WDONE : S_WCHK;
      end
      S_WDONE: begin
        cmd.rd_src = SRC_LAST;
        if (!stat.seen) begin
          cmd.fin = 1'b1;
          cmd.status = ST_NO_REC;
          state_next = S_IDLE;
        end else if (stat.short_ovf) begin
          cmd.fin = 1'b1;
          cmd.status = ST_SHORT_OVF;
          state_next = S_IDLE;
        end else if (stat.no_room) begin
          cmd.fin = 1'b1;
          cmd.status = ST_NO_ROOM;
          state_next = S_IDLE;
        end else begin
          cmd.act = ACT_WP_END;
          state_next = S_AMEW;
        end
      end
      S_AMEW: begin
        cmd.act = ACT_WR_ME;
        state_next = S_AHDR;
      end
      S_AHDR: begin
        cmd.act = ACT_WR_HDR;
        state_next = S_ATL;
      end
      S_ATL: begin
        cmd.act = ACT_WR_TL;
        state_next = S_APL;
      end
      S_APL: begin
        cmd.act = ACT_WR_PL;
        state_next = S_ATYPE;
      end
      S_ATYPE: begin
        cmd.act = ACT_WR_TYPE;
        if (stat.idx_type_last) begin
          state_next = S_APKR;
        end
      end
      S_APKR: state_next = S_APKW;
      S_APKW: begin
        cmd.act = ACT_WR_PKG;
        state_next = stat.idx_pkg_last ? S_ATERM : S_APKR;
      end
      S_ATERM: begin
        cmd.act = ACT_WR_TERM;
        state_next = S_ALEN;
      end
      S_ALEN: begin
        if (stat.hdr_long) begin
          cmd.act = ACT_WR_LENH;
          state_next = S_ALEN2;
        end else begin
          cmd.act = ACT_WR_LEN1;
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ALEN2: begin
        cmd.act = ACT_WR_LENL;
        cmd.fin = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> busy) else $error("inject finish outside an inject");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_LOADT || cmd.act == ACT_LOADP) |-> !busy && start)
    else $error("load outside accept");
  a_rd_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> $past(state == S_IDLE && start && operation == OP_READ))
    else $error("read result without read item");

endmodule
